// File: rtl/gql_pkg.sv
// shared types, codes and helpers for the glyph quad layout block
`timescale 1ns / 1ps

package gql_pkg;

    localparam int CMD_W      = 3;
    localparam int CODE_W     = 8;
    localparam int POS_W      = 24;
    localparam int PIX_W      = 9;
    localparam int SCALE_W    = 16;
    localparam int TEX_W      = 17;
    localparam int CORNER_W   = 3;
    localparam int LH_W       = 10;
    localparam int PAD_W      = 8;
    localparam int QLIM_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WIDE_W     = 30;
    localparam int S_TDATA_W  = 120;
    localparam int M_FIELDS_W = 85;
    localparam int M_TDATA_W  = 88;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE   = 8'd10;
    localparam logic [SCALE_W-1:0] SCALE_ONE      = 16'd256;
    localparam logic [QLIM_W-1:0]  QUAD_LIMIT_RST = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 3'd0,
        CMD_ORIGIN = 3'd1,
        CMD_SCALE  = 3'd2,
        CMD_CHAR   = 3'd3,
        CMD_END    = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_HEIGHT = 2'd0,
        CFG_PADDING     = 2'd1,
        CFG_QUAD_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [CORNER_W-1:0] {
        CORNER_TL0 = 3'd0,
        CORNER_BL  = 3'd1,
        CORNER_BR0 = 3'd2,
        CORNER_TL1 = 3'd3,
        CORNER_BR1 = 3'd4,
        CORNER_TR  = 3'd5
    } corner_t;

    typedef struct packed {
        logic        [PIX_W-1:0] adv;
        logic signed [PIX_W-1:0] yoff;
        logic signed [PIX_W-1:0] xoff;
        logic        [PIX_W-1:0] h;
        logic        [PIX_W-1:0] w;
        logic        [PIX_W-1:0] v;
        logic        [PIX_W-1:0] u;
    } glyph_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic        [CODE_W-1:0] code;
        logic signed [POS_W-1:0]  x_value;
        logic signed [POS_W-1:0]  y_value;
    } item_t;

    typedef struct packed {
        logic [LH_W-1:0]   line_height;
        logic [PAD_W-1:0]  padding_width;
        logic [QLIM_W-1:0] quad_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x_left;
        logic signed [POS_W-1:0] x_right;
        logic signed [POS_W-1:0] y_top;
        logic signed [POS_W-1:0] y_bot;
        logic        [TEX_W-1:0] u0;
        logic        [TEX_W-1:0] u1;
        logic        [TEX_W-1:0] v0;
        logic        [TEX_W-1:0] v1;
    } quad_t;

    // clamp a wide signed value into the 24-bit position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] res;
        if (v[WIDE_W-1:POS_W-1] == {(WIDE_W-POS_W+1){v[WIDE_W-1]}}) begin
            res = v[POS_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: rtl/gql_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module gql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gql_glyph_table.sv
// glyph table: ram plus per-entry valid bits so unwritten glyphs read as zero
`timescale 1ns / 1ps

module gql_glyph_table #(
    parameter int GLYPH_CODES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic                  rd_en,
    input  logic [gql_pkg::CODE_W-1:0] code,
    input  gql_pkg::glyph_t       wdata,
    output gql_pkg::glyph_t       rdata
);
    import gql_pkg::*;

    localparam int ADDR_W = $clog2(GLYPH_CODES);

    logic                   in_range;
    logic [ADDR_W-1:0]      addr;
    logic [GLYPH_CODES-1:0] valid_reg;
    logic [GLYPH_CODES-1:0] valid_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic [$bits(glyph_t)-1:0] ram_rdata;

    assign in_range = {1'b0, code} < (CODE_W + 1)'(GLYPH_CODES);
    assign addr     = code[ADDR_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        if (wr_en && in_range) begin
            valid_next[addr] = 1'b1;
        end
        hit_next = hit_reg;
        if (rd_en) begin
            hit_next = in_range && valid_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    gql_ram #(
        .WIDTH ($bits(glyph_t)),
        .DEPTH (GLYPH_CODES)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en && in_range),
        .waddr (addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // never-loaded or out-of-range codes give the all-zero glyph
    assign rdata = hit_reg ? glyph_t'(ram_rdata) : '0;

endmodule

// File: rtl/gql_layout.sv
// scale products, atlas coordinates and pen/origin/quad-count state
`timescale 1ns / 1ps

module gql_layout #(
    parameter int ATLAS_SIZE = 512
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  gql_pkg::cfg_t   cfg,
    input  logic            s1_valid,
    input  gql_pkg::item_t  s1_item,
    input  gql_pkg::glyph_t glyph,
    output logic            s1_ready,
    output logic            quad_valid,
    output gql_pkg::quad_t  quad,
    input  logic            quad_ready
);
    import gql_pkg::*;

    // pix * 2^16 / ATLAS_SIZE through a rounded-up reciprocal, exact for 10-bit pixels
    localparam int TEX_SHIFT = 38;
    localparam int TEX_MUL_W = 33;
    localparam int TEX_PROD_W = TEX_MUL_W + 10;
    localparam int TEX_Q_W = TEX_PROD_W - (TEX_SHIFT - 16);
    localparam logic [TEX_MUL_W-1:0] TEX_MUL = TEX_MUL_W'(
        ((64'd1 << TEX_SHIFT) + 64'(ATLAS_SIZE) - 64'd1) / 64'(ATLAS_SIZE));

    typedef struct packed {
        cmd_t                    cmd;
        logic                    newline;
        logic signed [POS_W-1:0] x_value;
        logic signed [POS_W-1:0] y_value;
        logic signed [25:0]      xoff_sx;
        logic signed [27:0]      hy_sy;
        logic        [24:0]      w_sx;
        logic        [24:0]      h_sy;
        logic signed [26:0]      adv_sx;
        logic        [25:0]      nl_step;
        logic        [TEX_W-1:0] u0;
        logic        [TEX_W-1:0] u1;
        logic        [TEX_W-1:0] v0;
        logic        [TEX_W-1:0] v1;
    } stage_t;

    function automatic logic [TEX_W-1:0] tex_coord(input logic [9:0] pix);
        logic [TEX_PROD_W-1:0] prod;
        logic [TEX_Q_W-1:0]    q;
        prod = TEX_PROD_W'(pix) * TEX_PROD_W'(TEX_MUL);
        q    = TEX_Q_W'(prod >> (TEX_SHIFT - 16));
        return (|q[TEX_Q_W-1:TEX_W]) ? {TEX_W{1'b1}} : q[TEX_W-1:0];
    endfunction

    logic [SCALE_W-1:0] scale_x_reg, scale_x_next;
    logic [SCALE_W-1:0] scale_y_reg, scale_y_next;
    logic signed [10:0] hy;
    logic signed [9:0]  adv_pad;
    stage_t             s2_next;
    stage_t             s2_reg;
    logic               s2_valid_reg;
    logic               s1_take;

    logic signed [POS_W-1:0]  pen_x_reg, pen_x_next;
    logic signed [POS_W-1:0]  pen_y_reg, pen_y_next;
    logic signed [POS_W-1:0]  origin_x_reg, origin_x_next;
    logic        [QLIM_W-1:0] quad_count_reg, quad_count_next;
    logic                     quad_ok;
    logic                     s2_emit;
    logic                     s2_done;
    logic signed [26:0]       xpos;
    logic signed [28:0]       ypos;
    logic signed [27:0]       x_right;
    logic signed [29:0]       y_top;
    logic signed [27:0]       pen_x_adv;
    logic signed [27:0]       pen_y_nl;

    // first stage: every product and texture coordinate, registered
    assign hy      = 11'($signed({2'b00, glyph.h})) + 11'(glyph.yoff);
    assign adv_pad = 10'($signed({1'b0, glyph.adv})) - 10'($signed({2'b00, cfg.padding_width}));

    always_comb begin
        s2_next.cmd     = s1_item.cmd;
        s2_next.newline = s1_item.code == NEWLINE_CODE;
        s2_next.x_value = s1_item.x_value;
        s2_next.y_value = s1_item.y_value;
        s2_next.xoff_sx = 26'(glyph.xoff) * 26'($signed({1'b0, scale_x_reg}));
        s2_next.hy_sy   = 28'(hy) * 28'($signed({1'b0, scale_y_reg}));
        s2_next.w_sx    = 25'(glyph.w) * 25'(scale_x_reg);
        s2_next.h_sy    = 25'(glyph.h) * 25'(scale_y_reg);
        s2_next.adv_sx  = 27'(adv_pad) * 27'($signed({1'b0, scale_x_reg}));
        s2_next.nl_step = 26'(cfg.line_height) * 26'(scale_y_reg);
        s2_next.u0      = tex_coord({1'b0, glyph.u});
        s2_next.u1      = tex_coord(10'(glyph.u) + 10'(glyph.w));
        s2_next.v0      = tex_coord({1'b0, glyph.v});
        s2_next.v1      = tex_coord(10'(glyph.v) + 10'(glyph.h));
    end

    assign s1_take = s1_valid && s1_ready;

    // scale lives with the first stage since only the products use it
    always_comb begin
        scale_x_next = scale_x_reg;
        scale_y_next = scale_y_reg;
        if (s1_take && s1_item.cmd == CMD_SCALE) begin
            scale_x_next = s1_item.x_value[SCALE_W-1:0];
            scale_y_next = s1_item.y_value[SCALE_W-1:0];
        end
    end

    // second stage: positions against the pen, pen and quad count update
    assign quad_ok    = quad_count_reg < cfg.quad_limit;
    assign s2_emit    = s2_reg.cmd == CMD_CHAR && !s2_reg.newline && quad_ok;
    assign s2_done    = s2_valid_reg && (!s2_emit || quad_ready);
    assign s1_ready   = !s2_valid_reg || s2_done;
    assign quad_valid = s2_valid_reg && s2_emit;

    assign xpos      = 27'(pen_x_reg) + 27'(s2_reg.xoff_sx);
    assign ypos      = 29'(pen_y_reg) - 29'(s2_reg.hy_sy);
    assign x_right   = 28'(xpos) + 28'($signed({1'b0, s2_reg.w_sx}));
    assign y_top     = 30'(ypos) + 30'($signed({1'b0, s2_reg.h_sy}));
    assign pen_x_adv = 28'(pen_x_reg) + 28'(s2_reg.adv_sx);
    assign pen_y_nl  = 28'(pen_y_reg) - 28'($signed({1'b0, s2_reg.nl_step}));

    always_comb begin
        quad.x_left  = sat_pos(30'(xpos));
        quad.x_right = sat_pos(30'(x_right));
        quad.y_top   = sat_pos(y_top);
        quad.y_bot   = sat_pos(30'(ypos));
        quad.u0      = s2_reg.u0;
        quad.u1      = s2_reg.u1;
        quad.v0      = s2_reg.v0;
        quad.v1      = s2_reg.v1;
    end

    always_comb begin
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        origin_x_next   = origin_x_reg;
        quad_count_next = quad_count_reg;
        if (s2_done) begin
            unique case (s2_reg.cmd)
                CMD_ORIGIN: begin
                    origin_x_next = s2_reg.x_value;
                    pen_x_next    = s2_reg.x_value;
                    pen_y_next    = s2_reg.y_value;
                end
                CMD_END: begin
                    quad_count_next = '0;
                end
                CMD_CHAR: begin
                    if (s2_reg.newline) begin
                        pen_x_next = origin_x_reg;
                        pen_y_next = sat_pos(30'(pen_y_nl));
                    end else if (quad_ok) begin
                        pen_x_next      = sat_pos(30'(pen_x_adv));
                        quad_count_next = quad_count_reg + QLIM_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg    <= SCALE_ONE;
            scale_y_reg    <= SCALE_ONE;
            s2_valid_reg   <= 1'b0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            origin_x_reg   <= '0;
            quad_count_reg <= '0;
        end else begin
            scale_x_reg    <= scale_x_next;
            scale_y_reg    <= scale_y_next;
            if (s1_ready) begin
                s2_valid_reg <= s1_valid;
            end
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            origin_x_reg   <= origin_x_next;
            quad_count_reg <= quad_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take) begin
            s2_reg <= s2_next;
        end
    end

endmodule

// File: rtl/gql_vertex_seq.sv
// vertex sequencer: holds one quad and emits its six vertices in order
`timescale 1ns / 1ps

module gql_vertex_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           quad_valid,
    input  gql_pkg::quad_t                 quad,
    output logic                           quad_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gql_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import gql_pkg::*;

    logic    busy_reg, busy_next;
    corner_t corner_reg, corner_next;
    quad_t   quad_reg;
    logic    last;
    logic    load;

    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic        [TEX_W-1:0] tu;
    logic        [TEX_W-1:0] tv;

    assign last       = corner_reg == CORNER_TR;
    assign quad_ready = !busy_reg || (m_tready && last);
    assign load       = quad_valid && quad_ready;

    always_comb begin
        busy_next   = busy_reg;
        corner_next = corner_reg;
        if (load) begin
            busy_next   = 1'b1;
            corner_next = CORNER_TL0;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                corner_next = corner_t'(corner_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            corner_reg <= CORNER_TL0;
        end else begin
            busy_reg   <= busy_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            quad_reg <= quad;
        end
    end

    always_comb begin
        unique case (corner_reg)
            CORNER_BL: begin
                vx = quad_reg.x_left;  vy = quad_reg.y_bot; tu = quad_reg.u0; tv = quad_reg.v1;
            end
            CORNER_BR0, CORNER_BR1: begin
                vx = quad_reg.x_right; vy = quad_reg.y_bot; tu = quad_reg.u1; tv = quad_reg.v1;
            end
            CORNER_TR: begin
                vx = quad_reg.x_right; vy = quad_reg.y_top; tu = quad_reg.u1; tv = quad_reg.v0;
            end
            default: begin
                vx = quad_reg.x_left;  vy = quad_reg.y_top; tu = quad_reg.u0; tv = quad_reg.v0;
            end
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, CORNER_W'(corner_reg), tv, tu, vy, vx};

    a_corner_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tready && !last
        |=> busy_reg && corner_reg == corner_t'($past(corner_reg) + 3'd1))
        else $error("vertex corner did not advance by one");

    a_quad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        quad_valid && quad_ready |=> m_tvalid && corner_reg == CORNER_TL0)
        else $error("new quad did not start at the first corner");

    a_quad_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && !quad_valid |=> !m_tvalid)
        else $error("vertex output stayed valid after the last corner");

endmodule

// File: rtl/glyph_quad_layout_core.sv
// Glyph quad layout core. Takes font commands on the s_ stream (load glyph, set origin,
// set scale, place character, end frame) and produces six triangle vertices per placed
// glyph on the m_ stream, in the order TL, BL, BR, TL, BR, TR with tlast on the sixth.
// Commands that make no vertices are taken one per cycle unless a glyph ahead is held by the
// output; a placed glyph occupies the output while the vertex sequencer sends one vertex per
// cycle as m_tready allows, and the next character is taken while those vertices drain. The
// first vertex follows the character request through the glyph ram read, the product stage and
// the position stage, which loads the vertex sequencer. The glyph table reads as all zero after
// reset through per-entry valid bits, so there is no clearing pass. Configuration writes
// (line height, padding, quad limit) are taken on any cycle but must only be made while
// the block is idle. Positions are signed Q16.8 and saturate; texture coordinates are
// Q1.16 of the atlas size.
`timescale 1ns / 1ps

module glyph_quad_layout_core #(
    parameter int GLYPH_CODES = 256,
    parameter int ATLAS_SIZE  = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // code, x_value, y_value, glyph_u, glyph_v, glyph_w, glyph_h, glyph_xoff,
    // glyph_yoff, glyph_adv (lowest bits first)
    input  logic [gql_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic [gql_pkg::CMD_W-1:0]         s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex_x, vertex_y, tex_u, tex_v, corner (lowest bits first)
    output logic [gql_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [gql_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gql_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import gql_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    item_t  s1_item_reg;
    item_t  s_item;
    glyph_t s_glyph;
    glyph_t glyph_rd;
    logic   s1_valid_reg, s1_valid_next;
    logic   s1_take;
    logic   accept;
    logic   quad_valid;
    logic   quad_ready;
    quad_t  quad;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_HEIGHT: cfg_next.line_height   = cfg_wdata[LH_W-1:0];
                CFG_PADDING:     cfg_next.padding_width = cfg_wdata[PAD_W-1:0];
                CFG_QUAD_LIMIT:  cfg_next.quad_limit    = cfg_wdata[QLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.cmd     = cmd_t'(s_tuser);
    assign s_item.code    = s_tdata[7:0];
    assign s_item.x_value = s_tdata[31:8];
    assign s_item.y_value = s_tdata[55:32];

    assign s_glyph.u    = s_tdata[64:56];
    assign s_glyph.v    = s_tdata[73:65];
    assign s_glyph.w    = s_tdata[82:74];
    assign s_glyph.h    = s_tdata[91:83];
    assign s_glyph.xoff = s_tdata[100:92];
    assign s_glyph.yoff = s_tdata[109:101];
    assign s_glyph.adv  = s_tdata[118:110];

    // stage 1 waits on the glyph ram read; it can refill as it drains
    assign s_tready = !s1_valid_reg || s1_take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_take) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_height   <= '0;
            cfg_reg.padding_width <= '0;
            cfg_reg.quad_limit    <= QUAD_LIMIT_RST;
            s1_valid_reg          <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_item;
        end
    end

    gql_glyph_table #(
        .GLYPH_CODES (GLYPH_CODES)
    ) u_glyph_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && s_item.cmd == CMD_LOAD),
        .rd_en   (accept),
        .code    (s_item.code),
        .wdata   (s_glyph),
        .rdata   (glyph_rd)
    );

    gql_layout #(
        .ATLAS_SIZE (ATLAS_SIZE)
    ) u_layout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s1_valid   (s1_valid_reg),
        .s1_item    (s1_item_reg),
        .glyph      (glyph_rd),
        .s1_ready   (s1_take),
        .quad_valid (quad_valid),
        .quad       (quad),
        .quad_ready (quad_ready)
    );

    gql_vertex_seq u_vertex_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .quad_valid (quad_valid),
        .quad       (quad),
        .quad_ready (quad_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_take |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stalled stage 1 request was lost or changed");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted request did not reach stage 1");

endmodule

// File: test/glyph_quad_layout_core_tb.sv
// self-checking testbench for the glyph quad layout core: font command stream in, vertex stream out
`timescale 1ns / 1ps

module glyph_quad_layout_core_tb;
    import gql_pkg::*;

    localparam int GLYPH_CODES      = 256;
    localparam int ATLAS_SIZE       = 512;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 10;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;
    localparam int SEG_ITEMS        = 36;
    localparam int LH_MAX           = 999;
    localparam int PAD_MAX          = 255;
    localparam int POOL_BASE        = 60;
    localparam int POOL_SIZE        = 8;
    localparam int POS_MAX          = 8388607;
    localparam int POS_MIN          = -8388608;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  xv;
        logic [POS_W-1:0]  yv;
        logic [PIX_W-1:0]  gu;
        logic [PIX_W-1:0]  gv;
        logic [PIX_W-1:0]  gw;
        logic [PIX_W-1:0]  gh;
        logic [PIX_W-1:0]  gxoff;
        logic [PIX_W-1:0]  gyoff;
        logic [PIX_W-1:0]  gadv;
    } font_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [TEX_W-1:0]        u;
        logic [TEX_W-1:0]        v;
        logic [CORNER_W-1:0]     corner;
        logic                    last;
    } vertex_t;

    typedef struct {
        int u, v, w, h, xoff, yoff, adv;
    } glyph_rec_t;

    function automatic int clamp_pos(input longint val);
        if (val > POS_MAX) return POS_MAX;
        if (val < POS_MIN) return POS_MIN;
        return int'(val);
    endfunction

    function automatic int atlas_coord(input int pix);
        longint t;
        t = (longint'(pix) * 65536) / ATLAS_SIZE;
        return (t > 131071) ? 131071 : int'(t);
    endfunction

    class vertex_scoreboard;
        glyph_rec_t glyphs[GLYPH_CODES];
        int pen_x, pen_y, origin_x;
        int scale_x, scale_y;
        int quad_count;
        int line_height, padding_width, quad_limit;
        vertex_t expected_vertices[$];
        int mismatches;

        function new();
            foreach (glyphs[i]) glyphs[i] = '{0, 0, 0, 0, 0, 0, 0};
            pen_x = 0;
            pen_y = 0;
            origin_x = 0;
            scale_x = SCALE_ONE;
            scale_y = SCALE_ONE;
            quad_count = 0;
            line_height = 0;
            padding_width = 0;
            quad_limit = QUAD_LIMIT_RST;
            mismatches = 0;
        endfunction

        function void set_regs(input int lh, input int pad, input int lim);
            line_height = lh % (1 << LH_W);
            padding_width = pad % (1 << PAD_W);
            quad_limit = lim % (1 << QLIM_W);
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        function void add_vertex(input int k, input longint x, input longint y,
                                 input int tu, input int tv);
            vertex_t vx;
            vx.x = POS_W'(clamp_pos(x));
            vx.y = POS_W'(clamp_pos(y));
            vx.u = TEX_W'(tu);
            vx.v = TEX_W'(tv);
            vx.corner = corner_t'(k);
            vx.last = (k == CORNER_TR);
            expected_vertices.insert(expected_vertices.size(), vx);
        endfunction

        function void note_request(input font_req_t r);
            glyph_rec_t g;
            longint xpos, ypos, wq, hq;
            int u0, u1, v0, v1;
            case (r.cmd)
                CMD_LOAD: begin
                    glyphs[r.code] = '{int'(r.gu), int'(r.gv), int'(r.gw), int'(r.gh),
                                       int'($signed(r.gxoff)), int'($signed(r.gyoff)),
                                       int'(r.gadv)};
                end
                CMD_ORIGIN: begin
                    origin_x = int'($signed(r.xv));
                    pen_x = origin_x;
                    pen_y = int'($signed(r.yv));
                end
                CMD_SCALE: begin
                    scale_x = int'(r.xv[SCALE_W-1:0]);
                    scale_y = int'(r.yv[SCALE_W-1:0]);
                end
                CMD_END: quad_count = 0;
                CMD_CHAR: begin
                    if (r.code == NEWLINE_CODE) begin
                        pen_x = origin_x;
                        pen_y = clamp_pos(longint'(pen_y)
                                          - longint'(line_height) * longint'(scale_y));
                    end else if (quad_count < quad_limit) begin
                        g = glyphs[r.code];
                        xpos = longint'(pen_x) + longint'(g.xoff) * scale_x;
                        ypos = longint'(pen_y) - (longint'(g.h) + g.yoff) * scale_y;
                        wq = longint'(g.w) * scale_x;
                        hq = longint'(g.h) * scale_y;
                        u0 = atlas_coord(g.u);
                        u1 = atlas_coord(g.u + g.w);
                        v0 = atlas_coord(g.v);
                        v1 = atlas_coord(g.v + g.h);
                        add_vertex(CORNER_TL0, xpos, ypos + hq, u0, v0);
                        add_vertex(CORNER_BL, xpos, ypos, u0, v1);
                        add_vertex(CORNER_BR0, xpos + wq, ypos, u1, v1);
                        add_vertex(CORNER_TL1, xpos, ypos + hq, u0, v0);
                        add_vertex(CORNER_BR1, xpos + wq, ypos, u1, v1);
                        add_vertex(CORNER_TR, xpos + wq, ypos + hq, u1, v0);
                        pen_x = clamp_pos(longint'(pen_x)
                                          + (longint'(g.adv) - padding_width) * scale_x);
                        quad_count = (quad_count + 1) % (1 << QLIM_W);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_vertex(input vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: vertex with nothing pending: x=%0d y=%0d u=%0d v=%0d c=%0d l=%0d",
                             $realtime, got.x, got.y, got.u, got.v, got.corner, got.last);
                return;
            end
            want = expected_vertices.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.u !== want.u ||
                got.v !== want.v || got.corner !== want.corner || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: vertex mismatch, expected x=%0d y=%0d u=%0d v=%0d c=%0d l=%0d",
                             $realtime, want.x, want.y, want.u, want.v, want.corner, want.last);
                    $display("%0t:                  got      x=%0d y=%0d u=%0d v=%0d c=%0d l=%0d",
                             $realtime, got.x, got.y, got.u, got.v, got.corner, got.last);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic long_hold_go;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   rx_cycle = 0;
    int   cycle_count = 0;
    int   burst_left;
    bit   offering;

    vertex_scoreboard sb;

    glyph_quad_layout_core #(
        .GLYPH_CODES(GLYPH_CODES),
        .ATLAS_SIZE (ATLAS_SIZE)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: one long hold-off when asked, otherwise a rotating stall pattern
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (long_hold_go && !hold_done) begin
            hold_cnt <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 4) != 0);
                default: m_tready <= ((rx_cycle % 9) < 4);
            endcase
        end
    end

    always @(posedge aclk) begin : request_mon
        font_req_t r;
        if (aresetn && s_tvalid && s_tready) begin
            {r.gadv, r.gyoff, r.gxoff, r.gh, r.gw, r.gv, r.gu, r.yv, r.xv, r.code} =
                s_tdata[S_TDATA_W-2:0];
            r.cmd = s_tuser;
            sb.note_request(r);
        end
    end

    always @(posedge aclk) begin : vertex_mon
        vertex_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[23:0];
            got.y = m_tdata[47:24];
            got.u = m_tdata[64:48];
            got.v = m_tdata[81:65];
            got.corner = m_tdata[84:82];
            got.last = m_tlast;
            sb.check_vertex(got);
        end
    end

    // offer one request, wait for it to be taken, then maybe pause the burst
    task automatic send(input font_req_t r);
        s_tdata <= {1'b0, r.gadv, r.gyoff, r.gxoff, r.gh, r.gw, r.gv, r.gu, r.yv, r.xv, r.code};
        s_tuser <= r.cmd;
        s_tvalid <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8);
        end
    endtask

    task automatic settle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        // the monitor notes the last accepted request at this same edge
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input int lh, input int pad, input int lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(lh);
        @(posedge aclk);
        cfg_index <= CFG_PADDING;
        cfg_wdata <= CFG_DATA_W'(pad);
        @(posedge aclk);
        cfg_index <= CFG_QUAD_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_regs(lh, pad, lim);
    endtask

    function automatic logic [POS_W-1:0] rnd_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] rnd_code();
        return CODE_W'($urandom);
    endfunction

    // unused fields carry random data
    function automatic font_req_t cmd_req(input logic [CMD_W-1:0] cmd,
                                          input logic [CODE_W-1:0] code,
                                          input logic [POS_W-1:0] xv,
                                          input logic [POS_W-1:0] yv);
        font_req_t r;
        r.cmd = cmd;
        r.code = code;
        r.xv = xv;
        r.yv = yv;
        r.gu = PIX_W'($urandom);
        r.gv = PIX_W'($urandom);
        r.gw = PIX_W'($urandom);
        r.gh = PIX_W'($urandom);
        r.gxoff = PIX_W'($urandom);
        r.gyoff = PIX_W'($urandom);
        r.gadv = PIX_W'($urandom);
        return r;
    endfunction

    function automatic font_req_t glyph_req(input logic [CODE_W-1:0] code,
                                            input int u, input int v, input int w,
                                            input int h, input int xoff, input int yoff,
                                            input int adv);
        font_req_t r;
        r = cmd_req(CMD_LOAD, code, rnd_pos(), rnd_pos());
        r.gu = PIX_W'(u);
        r.gv = PIX_W'(v);
        r.gw = PIX_W'(w);
        r.gh = PIX_W'(h);
        r.gxoff = PIX_W'(xoff);
        r.gyoff = PIX_W'(yoff);
        r.gadv = PIX_W'(adv);
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] CMD_CMD_UNUSED_PICK();
        return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    endfunction

    task automatic run_segment(input int lh, input int pad, input int lim);
        font_req_t r;
        int unsigned pick;
        write_regs(lh, pad, lim);
        for (int n = 0; n < SEG_ITEMS; n++) begin
            r = cmd_req(CMD_CHAR, rnd_code(), rnd_pos(), rnd_pos());
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                r.cmd = CMD_LOAD;
                if ($urandom_range(0, 3) != 0)
                    r.code = CODE_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
                // mostly glyphs of a realistic size
                if ($urandom_range(0, 2) != 0) begin
                    r.gu = PIX_W'($urandom_range(0, 480));
                    r.gv = PIX_W'($urandom_range(0, 480));
                    r.gw = PIX_W'($urandom_range(0, 32));
                    r.gh = PIX_W'($urandom_range(0, 32));
                    r.gxoff = PIX_W'($urandom_range(0, 16) - 8);
                    r.gyoff = PIX_W'($urandom_range(0, 40) - 36);
                    r.gadv = PIX_W'($urandom_range(0, 40));
                end
            end else if (pick < 22) begin
                r.cmd = CMD_ORIGIN;
                if ($urandom_range(0, 3) != 0) begin
                    r.xv = POS_W'($urandom_range(0, 200000) - 100000);
                    r.yv = POS_W'($urandom_range(0, 200000) - 100000);
                end
            end else if (pick < 29) begin
                r.cmd = CMD_SCALE;
                if ($urandom_range(0, 3) != 0) begin
                    r.xv[SCALE_W-1:0] = SCALE_W'($urandom_range(64, 1024));
                    r.yv[SCALE_W-1:0] = SCALE_W'($urandom_range(64, 1024));
                end
            end else if (pick < 34) begin
                r.cmd = CMD_END;
            end else if (pick < 37) begin
                r.cmd = CMD_CMD_UNUSED_PICK();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 12) r.code = NEWLINE_CODE;
                else if (pick < 88) r.code = CODE_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
            end
            send(r);
        end
        settle();
    endtask

    initial begin
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_LOAD;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_LINE_HEIGHT;
        cfg_wdata <= '0;
        long_hold_go <= 1'b0;
        burst_left = 4;
        offering = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: saturation corners, scale high bits, spare commands
        write_regs(16, 0, QUAD_LIMIT_RST);
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));     // glyph never loaded
        send(glyph_req(8'd255, 511, 511, 511, 511, 255, -256, 511));
        send(glyph_req(8'd0, 0, 0, 0, 0, -256, 255, 0));
        send(glyph_req(8'd65, 32, 64, 12, 18, 1, -14, 14));
        send(cmd_req(CMD_ORIGIN, rnd_code(), 24'h7FFFFF, 24'h800000));
        send(cmd_req(CMD_CHAR, 8'd255, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_ORIGIN, rnd_code(), 24'h800000, 24'h7FFFFF));
        send(cmd_req(CMD_CHAR, 8'd255, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, 8'd0, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, NEWLINE_CODE, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_SCALE, rnd_code(), 24'hFFFFFF, 24'h80FFFF));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, NEWLINE_CODE, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_SCALE, rnd_code(), 24'h7F0100, 24'hFF0080));
        send(cmd_req(CMD_ORIGIN, rnd_code(), 24'h000100, 24'h000000));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_UNUSED_FIRST, rnd_code(), rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_UNUSED_LAST, rnd_code(), rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_END, rnd_code(), rnd_pos(), rnd_pos()));
        settle();

        // zero quad budget: characters dropped, newline still moves the pen
        write_regs(LH_MAX, PAD_MAX, 0);
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, NEWLINE_CODE, rnd_pos(), rnd_pos()));
        settle();

        // budget of two, padding wider than the advance, frame end reopens it
        write_regs(0, PAD_MAX, 2);
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_END, rnd_code(), rnd_pos(), rnd_pos()));
        send(cmd_req(CMD_CHAR, 8'd65, rnd_pos(), rnd_pos()));
        settle();

        run_segment($urandom_range(0, LH_MAX), $urandom_range(0, 8), QUAD_LIMIT_RST);
        long_hold_go <= 1'b1;
        run_segment(LH_MAX, PAD_MAX, QUAD_LIMIT_RST);
        run_segment(0, 0, $urandom_range(2, 12));
        run_segment($urandom_range(0, LH_MAX), $urandom_range(0, PAD_MAX),
                    $urandom_range(1, QUAD_LIMIT_RST));

        if (sb.mismatches == 0 && sb.pending() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/gql_pkg.sv
rtl/gql_ram.sv
rtl/gql_glyph_table.sv
rtl/gql_layout.sv
rtl/gql_vertex_seq.sv
rtl/glyph_quad_layout_core.sv
test/glyph_quad_layout_core_tb.sv
